@@ rtl/ddtc_pkg.sv @@
`timescale 1ns / 1ps
package ddtc_pkg;

  // Field widths
  localparam int ANGLE_W = 15;   // Q3.12 signed angle
  localparam int LEN_W   = 16;   // Q8.8 heading length
  localparam int THR_W   = 14;   // Q2.12 unsigned thresholds
  localparam int SPD_W   = 15;   // Q7.8 speed limit
  localparam int OUT_W   = 17;   // Q9.8 signed wheel speed
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  // Soft-turn product and rounded division widths
  localparam int PROD_W = SPD_W + THR_W;      // base * (hard - |a|)
  localparam int DVD_W  = PROD_W + 1;         // 2 * product + hard
  localparam int DVS_W  = THR_W + 1;          // 2 * hard
  localparam int QUO_W  = SPD_W;              // quotient never exceeds base
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  // Turning modes
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOFT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HARD = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD  = 2'd3;

  // Reset values
  localparam logic [THR_W-1:0] HARD_THR_RST = 14'd3660;
  localparam logic [THR_W-1:0] SOFT_THR_RST = 14'd1430;
  localparam logic [THR_W-1:0] NONE_THR_RST = 14'd715;
  localparam logic [SPD_W-1:0] MAX_SPD_RST  = 15'd2560;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/ddtc_in_if.sv @@
`timescale 1ns / 1ps
interface ddtc_in_if import ddtc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] heading_angle;
  logic [LEN_W-1:0]          heading_length;

  modport source (output valid, heading_angle, heading_length, input ready);
  modport sink   (input valid, heading_angle, heading_length, output ready);
endinterface

@@ rtl/ddtc_out_if.sv @@
`timescale 1ns / 1ps
interface ddtc_out_if import ddtc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_speed;
  logic signed [OUT_W-1:0] right_speed;
  logic [MODE_W-1:0]       turn_mode;

  modport source (output valid, left_speed, right_speed, turn_mode, input ready);
  modport sink   (input valid, left_speed, right_speed, turn_mode, output ready);
endinterface

@@ rtl/differential_drive_turn_control_top.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Word fields
// ---------+-----+-------------------------------------------------
// in_ch    | in  | heading_angle s15 Q3.12, heading_length u16 Q8.8
// out_ch   | out | left_speed s17, right_speed s17, turn_mode u2
// cfg_*    | in  | cfg_we, cfg_index u2, cfg_wdata u15 (no read-back)
//
// One word at a time. None and hard modes go from accept through evaluation
// to the output step; soft mode adds a multiply and a divide, using the
// 15-step serial divider that forms the rounded inner-wheel factor.
// in_ch.ready is high only while idle.
// Reset (rst_n low, synchronous) loads the default thresholds and speed
// and clears the mode to none. A stalled result waits in the output
// register; the sequencer holds the next result until that register frees.
module differential_drive_turn_control_top import ddtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ddtc_in_if.sink              in_ch,
  ddtc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [THR_W-1:0]        hard_r, soft_r, none_r;
  logic [SPD_W-1:0]        max_r;
  logic [MODE_W-1:0]       mode_r, mode_nxt;
  logic signed [ANGLE_W-1:0] ang_r;
  logic [LEN_W-1:0]        len_r;
  logic [ANGLE_W-1:0]      mag_r, mag;
  logic [SPD_W-1:0]        base_r, base;
  logic                    pos_r;
  logic signed [OUT_W-1:0] inner_r, outer;
  logic [PROD_W-1:0]       prod_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_left_r, out_right_r;
  logic [MODE_W-1:0]       out_mode_r;
  logic [QUO_W-1:0]        quotient;
  div_stat_t               div_stat;
  logic                    div_start;
  logic                    in_acc;
  logic                    out_free;
  logic [ANGLE_W-1:0]      hard_x, soft_x, none_x;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r <= HARD_THR_RST;
      soft_r <= SOFT_THR_RST;
      none_r <= NONE_THR_RST;
      max_r  <= MAX_SPD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HARD_THR: hard_r <= cfg_wdata[THR_W-1:0];
        CFG_SOFT_THR: soft_r <= cfg_wdata[THR_W-1:0];
        CFG_NONE_THR: none_r <= cfg_wdata[THR_W-1:0];
        CFG_MAX_SPD:  max_r  <= cfg_wdata[SPD_W-1:0];
      endcase
    end
  end

  // Magnitude, clamped base speed and mode hysteresis
  assign hard_x = {1'b0, hard_r};
  assign soft_x = {1'b0, soft_r};
  assign none_x = {1'b0, none_r};
  assign mag    = ang_r[ANGLE_W-1] ? ANGLE_W'(-ang_r) : ANGLE_W'(ang_r);
  assign base   = (len_r < {1'b0, max_r}) ? len_r[SPD_W-1:0] : max_r;

  always_comb begin
    mode_nxt = mode_r;
    if (mode_nxt == MODE_HARD && mag <= soft_x) begin
      mode_nxt = MODE_SOFT;
    end
    if (mode_nxt == MODE_SOFT) begin
      if (mag > hard_x) begin
        mode_nxt = MODE_HARD;
      end else if (mag <= none_x) begin
        mode_nxt = MODE_NONE;
      end
    end
    if (mode_nxt == MODE_NONE) begin
      if (mag > hard_x) begin
        mode_nxt = MODE_HARD;
      end else if (mag > none_x) begin
        mode_nxt = MODE_SOFT;
      end
    end
    if (mode_nxt != MODE_NONE && mode_nxt != MODE_SOFT && mode_nxt != MODE_HARD) begin
      mode_nxt = MODE_NONE;
    end
  end

  // Serial divider for the rounded soft factor
  assign div_start = (state_r == S_START);

  ddtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_W'({prod_r, 1'b0}) + DVD_W'(hard_r)),
    .divisor  ({hard_r, 1'b0}),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Outer wheel: spin at max in hard mode, else the complement to twice base
  assign outer = (mode_r == MODE_HARD) ? OUT_W'(max_r)
               : OUT_W'({base_r, 1'b0}) - inner_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = (mode_nxt == MODE_SOFT && hard_r != '0) ? S_MUL : S_OUT;
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_NONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EVAL) begin
        mode_r <= mode_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ang_r <= in_ch.heading_angle;
      len_r <= in_ch.heading_length;
    end
    if (state_r == S_EVAL) begin
      mag_r  <= mag;
      base_r <= base;
      pos_r  <= !ang_r[ANGLE_W-1] && (ang_r != '0);
      if (mode_nxt == MODE_HARD) begin
        inner_r <= -OUT_W'(max_r);
      end else begin
        inner_r <= OUT_W'(base);
      end
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(base_r) * PROD_W'(hard_r - mag_r[THR_W-1:0]);
    end
    if (state_r == S_DIV && div_stat.done) begin
      inner_r <= OUT_W'(quotient);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_left_r  <= pos_r ? inner_r : outer;
      out_right_r <= pos_r ? outer : inner_r;
      out_mode_r  <= mode_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_speed  = out_left_r;
  assign out_ch.right_speed = out_right_r;
  assign out_ch.turn_mode   = out_mode_r;

  // Checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == S_DIV)
    else $error("divider running outside the divide step");

  a_soft_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> (mag_r <= hard_x && mode_r == MODE_SOFT))
    else $error("soft factor started with angle above hard threshold");

  a_hard_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == MODE_HARD) |-> OUT_W'(out_left_r + out_right_r) == '0)
    else $error("hard turn wheels not opposite");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EVAL)
    else $error("accepted word not evaluated");

endmodule

@@ rtl/ddtc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUO_W bits, so the upper dividend bits start out below the divisor.
module ddtc_div import ddtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output div_stat_t        stat
);

  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]     shf_r, shf_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       trial;
  logic                 q_bit;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, shf_r[QUO_W-1]};
  assign q_bit = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[DVD_W-1:QUO_W];
      shf_nxt  = dividend[QUO_W-1:0];
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = q_bit ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      shf_nxt = {shf_r[QUO_W-2:0], q_bit};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = shf_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
